[src/npc_pkg.sv]
package npc_pkg;

  localparam int PAL_ENTRIES = 256;
  localparam int IDX_W       = $clog2(PAL_ENTRIES);
  localparam int CNT_W       = IDX_W + 1;
  localparam int CHAN_W      = 6;
  localparam int ENTRY_W     = 3 * CHAN_W;
  localparam int DIST_W      = 8;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] entry_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_word_t;

  typedef struct packed {
    logic       palette_ready;
    logic [7:0] best_index;
    logic [7:0] best_distance;
  } out_word_t;

  // Tag that travels alongside a palette read.
  typedef struct packed {
    logic             vld;
    logic             first;
    logic [IDX_W-1:0] idx;
  } scan_t;

endpackage

[src/nearest_palette_color_top.sv]
// A query walks ST_SCAN over every palette entry, then ST_DRAIN and ST_FINISH, before its
// result strobe; a query before any palette write skips the scan and goes to ST_FINISH.
// No new request is taken while busy, as the single palette read port scans
// one entry a cycle; a palette write gives no result.
// Reset: rst_n low clears control state; a clearing pass then zeroes the palette,
// one entry a cycle, with busy high. The receiver cannot stall.
module nearest_palette_color_top
  import npc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_strobe,
  output out_word_t out_word
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  localparam logic [CNT_W-1:0] LAST_ADDR = CNT_W'(PAL_ENTRIES - 1);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   addr_r, addr_nxt;
  logic               loaded_r, loaded_nxt;
  logic               ready_r, ready_nxt;
  logic [ENTRY_W-1:0] colour_r, colour_nxt;
  scan_t              scan_r, scan_nxt;
  logic               out_strobe_r, out_strobe_nxt;
  out_word_t          out_word_r, out_word_nxt;

  logic               accept;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic               rd_en;
  logic [ENTRY_W-1:0] rd_data;
  logic [IDX_W-1:0]   best_idx;
  logic [DIST_W-1:0]  best_dist;
  logic               idx_in_range;

  assign busy         = (state_r != ST_IDLE);
  assign accept       = start && !busy;
  assign idx_in_range = ({1'b0, in_word.entry_index} < 9'(PAL_ENTRIES));

  // Palette store: one write port shared by the clearing pass and palette writes,
  // one read port owned by the scan.
  npc_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (addr_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  // Distance and running minimum, fed one entry a cycle, each in the cycle after its read.
  npc_dist u_dist (
    .clk       (clk),
    .scan      (scan_r),
    .entry     (rd_data),
    .colour    (colour_r),
    .best_idx  (best_idx),
    .best_dist (best_dist)
  );

  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    loaded_nxt     = loaded_r;
    ready_nxt      = ready_r;
    colour_nxt     = colour_r;
    scan_nxt       = '0;
    out_strobe_nxt = 1'b0;
    out_word_nxt   = out_word_r;
    wr_en          = 1'b0;
    wr_addr        = in_word.entry_index[IDX_W-1:0];
    wr_data        = {in_word.red[CHAN_W-1:0], in_word.green[CHAN_W-1:0],
                      in_word.blue[CHAN_W-1:0]};
    rd_en          = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        // After reset, zero the palette one entry a cycle.
        wr_en   = 1'b1;
        wr_addr = addr_r[IDX_W-1:0];
        wr_data = '0;
        if (addr_r == LAST_ADDR) begin
          addr_nxt  = '0;
          state_nxt = ST_IDLE;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_word.req_type == REQ_WRITE) begin
            // Drop writes beyond the palette entirely.
            if (idx_in_range) begin
              wr_en      = 1'b1;
              loaded_nxt = 1'b1;
            end
          end else begin
            colour_nxt = {in_word.red[7:2], in_word.green[7:2], in_word.blue[7:2]};
            addr_nxt   = '0;
            ready_nxt  = loaded_r;
            state_nxt  = loaded_r ? ST_SCAN : ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        // Issue one read a cycle; tag it so the distance unit knows the index.
        rd_en        = 1'b1;
        scan_nxt.vld   = 1'b1;
        scan_nxt.first = (addr_r == '0);
        scan_nxt.idx   = addr_r[IDX_W-1:0];
        if (addr_r == LAST_ADDR) begin
          addr_nxt  = '0;
          state_nxt = ST_DRAIN;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        // Last entry is being compared this cycle.
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        out_strobe_nxt = 1'b1;
        if (ready_r) begin
          out_word_nxt.palette_ready = 1'b1;
          out_word_nxt.best_index    = 8'(best_idx);
          out_word_nxt.best_distance = best_dist;
        end else begin
          out_word_nxt = '0;
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      addr_r       <= '0;
      loaded_r     <= 1'b0;
      ready_r      <= 1'b0;
      scan_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      addr_r       <= addr_nxt;
      loaded_r     <= loaded_nxt;
      ready_r      <= ready_nxt;
      scan_r       <= scan_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Hold payload without reset.
  always_ff @(posedge clk) begin
    colour_r   <= colour_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

endmodule

[src/npc_mem.sv]
module npc_mem
  import npc_pkg::*;
(
  input  logic               clk,
  input  logic               wr_en,
  input  logic [IDX_W-1:0]   wr_addr,
  input  logic [ENTRY_W-1:0] wr_data,
  input  logic               rd_en,
  input  logic [IDX_W-1:0]   rd_addr,
  output logic [ENTRY_W-1:0] rd_data
);

  logic [ENTRY_W-1:0] mem [PAL_ENTRIES];
  logic [ENTRY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[src/npc_dist.sv]
module npc_dist
  import npc_pkg::*;
(
  input  logic               clk,
  input  scan_t              scan,
  input  logic [ENTRY_W-1:0] entry,
  input  logic [ENTRY_W-1:0] colour,
  output logic [IDX_W-1:0]   best_idx,
  output logic [DIST_W-1:0]  best_dist
);

  logic [IDX_W-1:0]  best_idx_r;
  logic [DIST_W-1:0] best_dist_r;
  logic [CHAN_W-1:0] ad_r, ad_g, ad_b;
  logic [DIST_W-1:0] gap_sum;

  function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  always_comb begin
    ad_r    = abs_diff(colour[3*CHAN_W-1:2*CHAN_W], entry[3*CHAN_W-1:2*CHAN_W]);
    ad_g    = abs_diff(colour[2*CHAN_W-1:CHAN_W], entry[2*CHAN_W-1:CHAN_W]);
    ad_b    = abs_diff(colour[CHAN_W-1:0], entry[CHAN_W-1:0]);
    gap_sum = DIST_W'(ad_r) + DIST_W'(ad_g) + DIST_W'(ad_b);
  end

  // Strict less-than keeps the lowest index on a tie.
  always_ff @(posedge clk) begin
    if (scan.vld && (scan.first || (gap_sum < best_dist_r))) begin
      best_idx_r  <= scan.idx;
      best_dist_r <= gap_sum;
    end
  end

  assign best_idx  = best_idx_r;
  assign best_dist = best_dist_r;

endmodule
